### src/tpc_pkg.sv
// Package for the triangle plane clipper: coordinate, vertex and queue entry
// types, status and register codes, reset values and small helpers.
// No dependencies.
package tpc_pkg;

	localparam int CW         = 32;  // coordinate width, signed Q16.16
	localparam int DW         = 52;  // plane distance width, signed Q36.16
	localparam int PW         = 64;  // one normal x coordinate product
	localparam int FIFO_DEPTH = 4;
	localparam int CNT_W      = 3;   // holds 0..FIFO_DEPTH
	localparam int TW         = 17;  // crossing parameter, 0..65536
	localparam int RW         = DW + 2;  // divider remainder

	typedef logic signed [CW-1:0] coord_t;
	typedef coord_t [2:0] vtx_t;      // [0] x, [1] y, [2] z
	typedef vtx_t [2:0] verts_t;      // [0] a, [1] b, [2] c
	typedef logic signed [DW-1:0] dist_t;

	typedef logic [1:0] status_t;
	localparam status_t ST_NONE = 2'd0;
	localparam status_t ST_ALL  = 2'd1;
	localparam status_t ST_CLIP = 2'd2;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_NX  = 2'd0;
	localparam reg_idx_t REG_NY  = 2'd1;
	localparam reg_idx_t REG_NZ  = 2'd2;
	localparam reg_idx_t REG_OFS = 2'd3;

	localparam coord_t NX_RST  = 32'sd0;
	localparam coord_t NY_RST  = 32'sd65536;
	localparam coord_t NZ_RST  = 32'sd0;
	localparam coord_t OFS_RST = 32'sd0;

	typedef struct packed {
		verts_t     verts;
		dist_t [2:0] d;
		logic [2:0] keep;
	} qent_t;

	// end vertex of the edge that starts at vertex i
	function automatic logic [1:0] next_vtx(input logic [1:0] i);
		logic [1:0] r;
		case (i)
			2'd0:    r = 2'd1;
			2'd1:    r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

### src/tpc_ifs.sv
// Channel interfaces of the triangle plane clipper: triangle in, result out,
// register write. Depends on tpc_pkg.
interface tpc_tri_if import tpc_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t a_x, a_y, a_z;
	coord_t b_x, b_y, b_z;
	coord_t c_x, c_y, c_z;
	modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready);
	modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready);
endinterface

interface tpc_res_if import tpc_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t clip_status;
	coord_t  out_a_x, out_a_y, out_a_z;
	coord_t  out_b_x, out_b_y, out_b_z;
	coord_t  out_c_x, out_c_y, out_c_z;
	logic    last_of_run;
	modport source(output valid, clip_status, out_a_x, out_a_y, out_a_z,
		out_b_x, out_b_y, out_b_z, out_c_x, out_c_y, out_c_z, last_of_run,
		input ready);
	modport sink(input valid, clip_status, out_a_x, out_a_y, out_a_z,
		out_b_x, out_b_y, out_b_z, out_c_x, out_c_y, out_c_z, last_of_run,
		output ready);
endinterface

interface tpc_cfg_if import tpc_pkg::*; ();
	logic     valid;
	logic     ready;
	reg_idx_t index;
	coord_t   data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### src/triangle_plane_clipper.sv
// Top level of the triangle plane clipper: front end, queue, back end.
// Depends on tpc_pkg, tpc_ifs, tpc_front, tpc_fifo, tpc_back.
//
//  channel  | dir | beat carries
//  tri_in   | in  | three vertices a, b, c (x, y, z each)
//  res_out  | out | clip_status, one triangle, last_of_run
//  cfg      | in  | register index, write data
//
// Distances are registered in the front as products, then as sum and floor; a
// queue of four entries follows. The back emits a triangle fully kept or fully
// dropped directly, and a clipped one after the 17-step restoring dividers
// that form the crossing parameters. Reset is asynchronous and needs
// no clearing pass. A stalled output holds the back; the front keeps
// accepting while the queue has room.
module triangle_plane_clipper import tpc_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	tpc_tri_if.sink   tri_in,
	tpc_res_if.source res_out,
	tpc_cfg_if.sink   cfg
);

	logic             push, pop, empty;
	qent_t            push_data, head;
	logic [CNT_W-1:0] fifo_count;

	tpc_front u_front (
		.clk, .arst_n, .tri_in, .cfg, .fifo_count, .push, .push_data
	);

	tpc_fifo u_fifo (
		.clk, .arst_n, .push, .push_data, .pop, .head, .empty, .count(fifo_count)
	);

	tpc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk, .arst_n, .head, .empty, .pop, .res_out
	);

`ifndef NO_ASSERTIONS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= CNT_W'(FIFO_DEPTH))
		else $error("queue overfilled");

	a_all_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && (res_out.clip_status == ST_ALL || res_out.clip_status == ST_NONE)
		|-> res_out.last_of_run)
		else $error("unclipped result not last");

	a_second_half: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.ready && !res_out.last_of_run
		|=> res_out.valid && res_out.clip_status == ST_CLIP)
		else $error("second fan triangle missing");
`endif

endmodule

### src/tpc_front.sv
// Front end: plane registers, per-vertex distance pipeline (products, then
// sum and floor) and side classification. Depends on tpc_pkg, tpc_ifs.
module tpc_front import tpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	tpc_tri_if.sink          tri_in,
	tpc_cfg_if.sink          cfg,
	input  logic [CNT_W-1:0] fifo_count,
	output logic             push,
	output qent_t            push_data
);

	coord_t nrm_q [3];
	coord_t ofs_q;

	logic              v_s1, v_s2;
	logic signed [PW-1:0] prod_s1 [3][3];
	verts_t            verts_s1, verts_s2;
	dist_t [2:0]       d_s2;
	verts_t            in_verts;
	logic [CNT_W:0]    inflight;
	logic              accept;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_q[0] <= NX_RST;
			nrm_q[1] <= NY_RST;
			nrm_q[2] <= NZ_RST;
			ofs_q    <= OFS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_NX:  nrm_q[0] <= cfg.data;
				REG_NY:  nrm_q[1] <= cfg.data;
				REG_NZ:  nrm_q[2] <= cfg.data;
				REG_OFS: ofs_q    <= cfg.data;
			endcase
		end
	end

	// queue space is reserved for every beat still in the pipeline
	assign inflight = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(v_s1) + (CNT_W+1)'(v_s2);
	assign tri_in.ready = inflight < (CNT_W+1)'(FIFO_DEPTH);
	assign accept = tri_in.valid && tri_in.ready;

	always_comb begin
		in_verts[0] = {tri_in.a_z, tri_in.a_y, tri_in.a_x};
		in_verts[1] = {tri_in.b_z, tri_in.b_y, tri_in.b_x};
		in_verts[2] = {tri_in.c_z, tri_in.c_y, tri_in.c_x};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			verts_s1 <= in_verts;
			for (int k = 0; k < 3; k++)
				for (int j = 0; j < 3; j++)
					prod_s1[k][j] <= in_verts[k][j] * nrm_q[j];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [PW+1:0] sum;
		if (v_s1) begin
			verts_s2 <= verts_s1;
			for (int k = 0; k < 3; k++) begin
				sum = (PW+2)'(prod_s1[k][0]) + (PW+2)'(prod_s1[k][1])
					+ (PW+2)'(prod_s1[k][2]);
				d_s2[k] <= DW'(sum >>> 16) + DW'(ofs_q);
			end
		end
	end

	assign push = v_s2;
	always_comb begin
		push_data.verts = verts_s2;
		push_data.d     = d_s2;
		for (int k = 0; k < 3; k++)
			push_data.keep[k] = !d_s2[k][DW-1];
	end

endmodule

### src/tpc_fifo.sv
// Short queue of classified triangles between front and back end.
// Depends on tpc_pkg.
module tpc_fifo import tpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qent_t            push_data,
	input  logic             pop,
	output qent_t            head,
	output logic             empty,
	output logic [CNT_W-1:0] count
);

	localparam int AW = $clog2(FIFO_DEPTH);

	qent_t           mem_q [FIFO_DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign head  = mem_q[rd_q];
	assign empty = cnt_q == '0;
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

### src/tpc_back.sv
// Back end: crossing parameters by two restoring dividers, interpolation,
// saturation, polygon fan and the output register. Depends on tpc_pkg, tpc_ifs.
module tpc_back import tpc_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	input  qent_t  head,
	input  logic   empty,
	output logic   pop,
	tpc_res_if.source res_out
);

	localparam int SAT_W = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
	localparam logic signed [CW+2:0] SAT_HI = (CW+3)'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
	localparam logic signed [CW+2:0] SAT_LO = -SAT_HI - (CW+3)'(1);
	localparam int MW = CW + 1 + TW + 1;

	typedef enum logic [2:0] {B_IDLE, B_DIV, B_MUL, B_ADD, B_EMIT_A, B_EMIT_B} bstate_t;

	bstate_t   st_q;
	verts_t    verts_q;
	logic [2:0] keep_q;
	status_t   status_q;
	logic [1:0] ce_q [2];
	logic [RW-1:0] den_q [2];
	logic [RW-1:0] rem_q [2];
	logic [TW-1:0] quot_q [2];
	logic [4:0] cnt_q;
	logic signed [MW-1:0] prod_q [2][3];
	vtx_t      cp_q [2];
	logic      out_v_q;
	status_t   o_status_q;
	verts_t    o_verts_q;
	logic      o_last_q;

	// head-of-queue classification
	logic [2:0] h_cross;
	logic [1:0] h_kept;
	logic [1:0] h_ce [2];
	logic [RW-1:0] h_num [2];
	logic [RW-1:0] h_den [2];
	// polygon from the kept corners and crossing points
	logic [2:0] cross_q;
	vtx_t       poly [4];
	logic [2:0] n_poly;
	logic       out_free;
	logic       emit;

	always_comb begin
		logic found;
		dist_t ds, de;
		logic signed [DW:0] df;
		found  = 1'b0;
		h_kept = '0;
		h_ce[0] = '0;
		h_ce[1] = '0;
		for (int i = 0; i < 3; i++) begin
			h_cross[i] = head.keep[i] != head.keep[next_vtx(2'(i))];
			h_kept = h_kept + 2'(head.keep[i]);
			if (h_cross[i]) begin
				if (!found)
					h_ce[0] = 2'(i);
				else
					h_ce[1] = 2'(i);
				found = 1'b1;
			end
		end
		for (int c = 0; c < 2; c++) begin
			ds = head.d[h_ce[c]];
			de = head.d[next_vtx(h_ce[c])];
			df = (DW+1)'(ds) - (DW+1)'(de);
			h_num[c] = ds[DW-1] ? RW'(-(DW+1)'(ds)) : RW'(ds);
			h_den[c] = df[DW] ? RW'(-df) : RW'(df);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			cross_q[i] = keep_q[i] != keep_q[next_vtx(2'(i))];
		for (int s = 0; s < 4; s++)
			poly[s] = '0;
		n_poly = '0;
		for (int i = 0; i < 3; i++) begin
			if (keep_q[i]) begin
				poly[n_poly[1:0]] = verts_q[i];
				n_poly = n_poly + 3'd1;
			end
			if (cross_q[i]) begin
				poly[n_poly[1:0]] = (2'(i) == ce_q[0]) ? cp_q[0] : cp_q[1];
				n_poly = n_poly + 3'd1;
			end
		end
	end

	assign out_free = !out_v_q || res_out.ready;
	assign emit = out_free && (st_q == B_EMIT_A || st_q == B_EMIT_B);
	assign pop = (st_q == B_IDLE) && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		logic ge;
		logic [RW-1:0] sub;
		logic [1:0] e;
		logic signed [CW+2:0] sum;
		if (!arst_n) begin
			st_q    <= B_IDLE;
			out_v_q <= 1'b0;
		end else begin
			if (emit)
				out_v_q <= 1'b1;
			else if (res_out.ready)
				out_v_q <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					if (!empty) begin
						verts_q <= head.verts;
						keep_q  <= head.keep;
						for (int c = 0; c < 2; c++) begin
							ce_q[c]  <= h_ce[c];
							rem_q[c] <= h_num[c];
							den_q[c] <= h_den[c];
						end
						cnt_q <= 5'(TW - 1);
						if (h_kept == 2'd0) begin
							status_q <= ST_NONE;
							st_q     <= B_EMIT_A;
						end else if (h_cross == 3'b000) begin
							status_q <= ST_ALL;
							st_q     <= B_EMIT_A;
						end else begin
							status_q <= ST_CLIP;
							st_q     <= B_DIV;
						end
					end
				end
				B_DIV: begin
					for (int c = 0; c < 2; c++) begin
						ge  = rem_q[c] >= den_q[c];
						sub = ge ? rem_q[c] - den_q[c] : rem_q[c];
						rem_q[c]  <= {sub[RW-2:0], 1'b0};
						quot_q[c] <= {quot_q[c][TW-2:0], ge};
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0)
						st_q <= B_MUL;
				end
				B_MUL: begin
					for (int c = 0; c < 2; c++) begin
						e = next_vtx(ce_q[c]);
						for (int j = 0; j < 3; j++)
							prod_q[c][j] <= ((CW+1)'(verts_q[e][j]) - (CW+1)'(verts_q[ce_q[c]][j]))
								* $signed({1'b0, quot_q[c]});
					end
					st_q <= B_ADD;
				end
				B_ADD: begin
					for (int c = 0; c < 2; c++)
						for (int j = 0; j < 3; j++) begin
							sum = (CW+3)'(verts_q[ce_q[c]][j]) + (CW+3)'(prod_q[c][j] >>> 16);
							if (sum > SAT_HI)
								cp_q[c][j] <= CW'(SAT_HI);
							else if (sum < SAT_LO)
								cp_q[c][j] <= CW'(SAT_LO);
							else
								cp_q[c][j] <= CW'(sum);
						end
					st_q <= B_EMIT_A;
				end
				B_EMIT_A: begin
					if (out_free) begin
						o_status_q <= status_q;
						case (status_q)
							ST_NONE: begin
								o_verts_q <= '0;
								o_last_q  <= 1'b1;
								st_q      <= B_IDLE;
							end
							ST_ALL: begin
								o_verts_q <= verts_q;
								o_last_q  <= 1'b1;
								st_q      <= B_IDLE;
							end
							default: begin
								o_verts_q <= {poly[2], poly[1], poly[0]};
								o_last_q  <= n_poly != 3'd4;
								st_q      <= (n_poly == 3'd4) ? B_EMIT_B : B_IDLE;
							end
						endcase
					end
				end
				B_EMIT_B: begin
					if (out_free) begin
						o_status_q <= ST_CLIP;
						o_verts_q  <= {poly[3], poly[2], poly[0]};
						o_last_q   <= 1'b1;
						st_q       <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_comb begin
		res_out.valid       = out_v_q;
		res_out.clip_status = o_status_q;
		res_out.out_a_x     = o_verts_q[0][0];
		res_out.out_a_y     = o_verts_q[0][1];
		res_out.out_a_z     = o_verts_q[0][2];
		res_out.out_b_x     = o_verts_q[1][0];
		res_out.out_b_y     = o_verts_q[1][1];
		res_out.out_b_z     = o_verts_q[1][2];
		res_out.out_c_x     = o_verts_q[2][0];
		res_out.out_c_y     = o_verts_q[2][1];
		res_out.out_c_z     = o_verts_q[2][2];
		res_out.last_of_run = o_last_q;
	end

endmodule
